/* src/pcc_pkg.sv */
// shared types and constants of the password complexity checker
package pcc_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned CsrIndexWidth = 3;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_SHORT       = 3'd1,
      ST_FEW_UPPER   = 3'd2,
      ST_FEW_LOWER   = 3'd3,
      ST_FEW_DIGIT   = 3'd4,
      ST_FEW_SPECIAL = 3'd5
   } status_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_MIN_LENGTH  = 3'd0,
      CSR_MIN_UPPER   = 3'd1,
      CSR_MIN_LOWER   = 3'd2,
      CSR_MIN_DIGIT   = 3'd3,
      CSR_MIN_SPECIAL = 3'd4
   } csr_index_type;

   localparam logic [ByteWidth-1:0] MinLengthReset  = 8'd8;
   localparam logic [ByteWidth-1:0] MinUpperReset   = 8'd1;
   localparam logic [ByteWidth-1:0] MinLowerReset   = 8'd1;
   localparam logic [ByteWidth-1:0] MinDigitReset   = 8'd1;
   localparam logic [ByteWidth-1:0] MinSpecialReset = 8'd1;

endpackage

/* src/password_complexity_checker.sv */
// password complexity checker top level
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------
//  req     | in        | req_valid/req_stall | req_byte_value
//  rsp     | out       | rsp_valid/rsp_stall | rsp_status, rsp_char_total
//  csr     | in        | csr_write_enable    | csr_index, csr_write_data
//
//  one byte per cycle unless stalled; registered, then classified and counted in the next cycle
//  a terminator's status beat goes through the input and result registers once the output is free
//  latency is set by the input register and the result register, nothing iterates
//  reset is synchronous: counters clear, thresholds return to their defaults
//  a held status beat stalls the input only when a second terminator reaches the counters
module password_complexity_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_byte_value,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_char_total,
   input  logic       csr_write_enable,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_write_data
);

   typedef enum logic [2:0] {
      CLS_NONE,
      CLS_UPPER,
      CLS_LOWER,
      CLS_DIGIT,
      CLS_SPECIAL
   } class_type;

   function automatic class_type classify(input logic [7:0] b);
      class_type c;
      c = CLS_NONE;
      case (b) inside
         [8'h41:8'h5a]: c = CLS_UPPER;   // A..Z
         [8'h61:8'h7a]: c = CLS_LOWER;   // a..z
         [8'h30:8'h39]: c = CLS_DIGIT;   // 0..9
         8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26,
         8'h2a, 8'h28, 8'h29, 8'h2d, 8'h5f, 8'h2b, 8'h3d: c = CLS_SPECIAL;
         default: c = CLS_NONE;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      return (v == 8'hff) ? v : v + 8'd1;
   endfunction

   logic [7:0] min_length_ff, min_upper_ff, min_lower_ff, min_digit_ff, min_special_ff;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   logic [7:0] length_count_ff, upper_count_ff, lower_count_ff;
   logic [7:0] digit_count_ff, special_count_ff;
   logic [7:0] length_count_in, upper_count_in, lower_count_in;
   logic [7:0] digit_count_in, special_count_in;

   logic       out_valid_ff;
   logic [2:0] out_status_ff;
   logic [7:0] out_total_ff;

   logic                 out_free;
   logic                 is_term;
   logic                 advance;
   class_type            byte_class;
   pcc_pkg::status_type  status_in;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign is_term   = (in_byte_ff == 8'd0);
   assign advance   = in_valid_ff && (!is_term || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign byte_class = classify(in_byte_ff);

   always_comb begin
      length_count_in  = length_count_ff;
      upper_count_in   = upper_count_ff;
      lower_count_in   = lower_count_ff;
      digit_count_in   = digit_count_ff;
      special_count_in = special_count_ff;
      if (advance) begin
         if (is_term) begin
            length_count_in  = 8'd0;
            upper_count_in   = 8'd0;
            lower_count_in   = 8'd0;
            digit_count_in   = 8'd0;
            special_count_in = 8'd0;
         end else begin
            length_count_in = sat_inc(length_count_ff);
            case (byte_class)
               CLS_UPPER:   upper_count_in   = sat_inc(upper_count_ff);
               CLS_LOWER:   lower_count_in   = sat_inc(lower_count_ff);
               CLS_DIGIT:   digit_count_in   = sat_inc(digit_count_ff);
               CLS_SPECIAL: special_count_in = sat_inc(special_count_ff);
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      if (length_count_ff < min_length_ff) begin
         status_in = pcc_pkg::ST_SHORT;
      end else if (upper_count_ff < min_upper_ff) begin
         status_in = pcc_pkg::ST_FEW_UPPER;
      end else if (lower_count_ff < min_lower_ff) begin
         status_in = pcc_pkg::ST_FEW_LOWER;
      end else if (digit_count_ff < min_digit_ff) begin
         status_in = pcc_pkg::ST_FEW_DIGIT;
      end else if (special_count_ff < min_special_ff) begin
         status_in = pcc_pkg::ST_FEW_SPECIAL;
      end else begin
         status_in = pcc_pkg::ST_OK;
      end
   end

   // thresholds
   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff  <= pcc_pkg::MinLengthReset;
         min_upper_ff   <= pcc_pkg::MinUpperReset;
         min_lower_ff   <= pcc_pkg::MinLowerReset;
         min_digit_ff   <= pcc_pkg::MinDigitReset;
         min_special_ff <= pcc_pkg::MinSpecialReset;
      end else if (csr_write_enable) begin
         case (pcc_pkg::csr_index_type'(csr_index))
            pcc_pkg::CSR_MIN_LENGTH:  min_length_ff  <= csr_write_data;
            pcc_pkg::CSR_MIN_UPPER:   min_upper_ff   <= csr_write_data;
            pcc_pkg::CSR_MIN_LOWER:   min_lower_ff   <= csr_write_data;
            pcc_pkg::CSR_MIN_DIGIT:   min_digit_ff   <= csr_write_data;
            pcc_pkg::CSR_MIN_SPECIAL: min_special_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input register and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         length_count_ff  <= 8'd0;
         upper_count_ff   <= 8'd0;
         lower_count_ff   <= 8'd0;
         digit_count_ff   <= 8'd0;
         special_count_ff <= 8'd0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         length_count_ff  <= length_count_in;
         upper_count_ff   <= upper_count_in;
         lower_count_ff   <= lower_count_in;
         digit_count_ff   <= digit_count_in;
         special_count_ff <= special_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_byte_value;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && is_term) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && is_term) begin
         out_status_ff <= status_in;
         out_total_ff  <= length_count_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_char_total = out_total_ff;

endmodule

/* src/pcc_checker.sv */
// port checker for the password complexity checker, bound to the top level
module pcc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_status,
   input logic [7:0] rsp_char_total
);

   // input only backs up behind a held status beat
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while result side is free");

   // no beats straight after reset
   assert property (@(posedge clock)
      $fell(reset) |-> (!rsp_valid && !req_stall))
      else $error("beat pending after reset");

   // status code stays within the defined verdicts
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= pcc_pkg::ST_FEW_SPECIAL))
      else $error("undefined status code");

   // held status beat keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_status) && $stable(rsp_char_total)))
      else $error("stalled status beat changed");

endmodule

bind password_complexity_checker pcc_checker u_pcc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_char_total (rsp_char_total)
);
